// ----- hw/rtl/c_escape_unescaper_defines.svh -----
// ----------------------------------------------------------------------------
// C escape decoder - assertion macros
// Shared helpers for the concurrent checks in the RTL. Each macro expects
// clk_i in scope; CEU_ASSERT also expects rst_ni.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_UNESCAPER_DEFINES_SVH
`define C_ESCAPE_UNESCAPER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define CEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define CEU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CEU_ASSERT(lbl, prop, msg)
`define CEU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/ceu_pkg.sv -----
// ----------------------------------------------------------------------------
// ceu_pkg
// Types, character constants and lookup functions of the C escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ceu_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  // replay buffer never holds more than this, whatever the depth asked for
  localparam int PEND_CAP_MAX      = 17;
  localparam int OCT_DIGITS        = 3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_OCTAL  = 2'd2,
    MODE_HEX    = 2'd3
  } esc_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_REPLAY  = 2'd1,
    ST_SIMPLE0 = 2'd2,
    ST_SIMPLE1 = 2'd3
  } ctrl_state_e;

  // source of the byte loaded into the output register
  typedef enum logic [1:0] {
    SEL_FIRST = 2'd0,
    SEL_PEND  = 2'd1,
    SEL_S0    = 2'd2,
    SEL_S1    = 2'd3
  } out_sel_e;

  typedef struct packed {
    logic     take;
    logic     emit;
    out_sel_e sel;
    logic     last_run;
    logic     idx_inc;
  } ceu_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       dec_replay;
    logic [1:0] dec_simple;
    logic [1:0] lat_simple;
    logic       replay_end;
  } ceu_status_t;

  // single-character escapes; zero for anything else
  function automatic logic [7:0] single_map(logic [7:0] c);
    logic [7:0] m;
    unique case (c)
      8'h61:   m = 8'd7;   // a
      8'h62:   m = 8'd8;   // b
      8'h66:   m = 8'd12;  // f
      8'h6E:   m = 8'd10;  // n
      8'h72:   m = 8'd13;  // r
      8'h74:   m = 8'd9;   // t
      8'h76:   m = 8'd11;  // v
      8'h5C:   m = 8'h5C;
      8'h27:   m = 8'h27;
      8'h22:   m = 8'h22;
      8'h3F:   m = 8'h3F;
      default: m = 8'd0;
    endcase
    return m;
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // bit 4 flags a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39)      h = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) h = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) h = {1'b1, c[3:0] + 4'd9};
    else                               h = 5'd0;
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/c_escape_unescaper.sv -----
// ----------------------------------------------------------------------------
// c_escape_unescaper
// Stream decoder for C string escapes, with literal replay of bad escapes.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)  tlast          tuser (low bit up)
//  s_axis   in   in_byte[7:0]        end_of_string  -
//  m_axis   out  out_byte[7:0]       last_of_run    string_done, replay_overflow
//
//  s_axis_tready stays low until every result of the last byte is loaded. An
//  aborted escape sends its backslash, the held chars, then trailing bytes, one
//  result a cycle through the single output register while m_axis_tready is high;
//  up to PENDING_DEPTH chars are held, never more than 17.
//  Reset clears the escape state; the replay buffer is not cleared.
//  m_axis_tready low with a result held keeps it and keeps s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_unescaper
  import ceu_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // in_byte
  input  wire        s_axis_tlast,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // string_done, replay_overflow
);

  ceu_cmd_t    cmd;
  ceu_status_t status;
  logic        done, ovf;

  ceu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ceu_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (done),
    .out_ovf_o   (ovf)
  );

  assign m_axis_tuser = {ovf, done};

endmodule

`default_nettype wire

// ----- hw/rtl/ceu_ctrl.sv -----
// ----------------------------------------------------------------------------
// ceu_ctrl
// Sequencer: accepts a byte, then steps through the replay and the plain
// bytes that the datapath has planned for it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "c_escape_unescaper_defines.svh"

module ceu_ctrl
  import ceu_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  ceu_status_t status_i,
  output ceu_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{take: 1'b0, emit: 1'b0, sel: SEL_FIRST, last_run: 1'b0, idx_inc: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.take = 1'b1;
          if (status_i.dec_replay) begin
            // backslash of the aborted escape goes out now
            cmd_o.emit = 1'b1;
            state_d    = ST_REPLAY;
          end else if (status_i.dec_simple != 2'd0) begin
            cmd_o.emit     = 1'b1;
            cmd_o.last_run = (status_i.dec_simple == 2'd1);
            if (status_i.dec_simple == 2'd2) state_d = ST_SIMPLE1;
          end
        end
      end
      ST_REPLAY: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_PEND;
          cmd_o.idx_inc  = 1'b1;
          cmd_o.last_run = status_i.replay_end && (status_i.lat_simple == 2'd0);
          if (status_i.replay_end) begin
            state_d = (status_i.lat_simple != 2'd0) ? ST_SIMPLE0 : ST_IDLE;
          end
        end
      end
      ST_SIMPLE0: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_S0;
          cmd_o.last_run = (status_i.lat_simple == 2'd1);
          state_d        = (status_i.lat_simple == 2'd2) ? ST_SIMPLE1 : ST_IDLE;
        end
      end
      ST_SIMPLE1: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_S1;
          cmd_o.last_run = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `CEU_ASSERT(a_s0_has_bytes, state_q == ST_SIMPLE0 |-> status_i.lat_simple != 2'd0, "s0 empty")
  `CEU_ASSERT(a_s1_has_two, state_q == ST_SIMPLE1 |-> status_i.lat_simple == 2'd2, "s1 not planned")
  `CEU_ASSERT(a_replay_next,
    cmd_o.take && status_i.dec_replay |=> state_q == ST_REPLAY, "replay not entered")

endmodule

`default_nettype wire

// ----- hw/rtl/ceu_datapath.sv -----
// ----------------------------------------------------------------------------
// ceu_datapath
// Escape state, replay buffer, per-byte decode and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "c_escape_unescaper_defines.svh"

module ceu_datapath
  import ceu_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [7:0]  in_byte_i,
  input  wire         in_last_i,
  input  ceu_cmd_t    cmd_i,
  output ceu_status_t status_o,
  input  wire         out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        out_done_o,
  output logic        out_ovf_o
);

  localparam int PEND_CAP = (PENDING_DEPTH < PEND_CAP_MAX) ? PENDING_DEPTH : PEND_CAP_MAX;
  localparam int CNT_W    = $clog2(PEND_CAP + 1);
  localparam int IDX_W    = $clog2(PEND_CAP);

  // working copy of the escape state plus the output plan of one byte
  typedef struct packed {
    esc_mode_e        mode;
    logic [31:0]      val;
    logic [CNT_W-1:0] cnt;
    logic             lost;
    logic             push;
    logic             rp_en;
    logic [CNT_W-1:0] rp_len;
    logic             rp_ovf;
    logic [1:0]       s_cnt;
    logic [7:0]       s0;
    logic [7:0]       s1;
  } work_t;

  function automatic work_t emit_b(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (w.s_cnt == 2'd0) r.s0 = b;
    else                 r.s1 = b;
    r.s_cnt = w.s_cnt + 2'd1;
    return r;
  endfunction

  function automatic work_t clear_esc(work_t w);
    work_t r;
    r      = w;
    r.mode = MODE_IDLE;
    r.val  = '0;
    r.cnt  = '0;
    r.lost = 1'b0;
    return r;
  endfunction

  function automatic work_t replay(work_t w);
    work_t r;
    r        = w;
    r.rp_en  = 1'b1;
    r.rp_len = w.cnt;
    r.rp_ovf = w.lost;
    return r;
  endfunction

  function automatic work_t push_c(work_t w);
    work_t r;
    r = w;
    if (w.cnt < CNT_W'(PEND_CAP)) begin
      r.push = 1'b1;
      r.cnt  = w.cnt + CNT_W'(1);
    end else begin
      r.lost = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t finish_esc(work_t w);
    work_t r;
    logic  big;
    r   = w;
    big = (w.val[31:8] != '0);
    unique case (w.mode)
      MODE_IDLE:   r = w;
      MODE_BSLASH: r = emit_b(w, CH_BSLASH);
      MODE_OCTAL:  r = big ? replay(w) : emit_b(w, w.val[7:0]);
      MODE_HEX: begin
        // 'x' with no digits counts as malformed
        if (big || (w.cnt < CNT_W'(2))) r = replay(w);
        else                            r = emit_b(w, w.val[7:0]);
      end
    endcase
    return clear_esc(r);
  endfunction

  function automatic work_t take_idle(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_BSLASH) r.mode = MODE_BSLASH;
    else                r = emit_b(w, c);
    return r;
  endfunction

  esc_mode_e        mode_q;
  logic [31:0]      val_q;
  logic [CNT_W-1:0] cnt_q;
  logic             lost_q;
  logic [7:0]       pend_q [PEND_CAP];

  logic [IDX_W-1:0] idx_q;
  logic [1:0]       s_cnt_q;
  logic [CNT_W-1:0] rp_len_q;
  logic             rp_ovf_q;
  logic [7:0]       s0_q, s1_q;
  logic             last_q;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q, out_done_q, out_ovf_q;

  work_t      dec;
  logic [7:0] smap;
  logic [4:0] hv;

  always_comb begin
    dec      = '0;
    dec.mode = mode_q;
    dec.val  = val_q;
    dec.cnt  = cnt_q;
    dec.lost = lost_q;
    smap     = single_map(in_byte_i);
    hv       = hex_val(in_byte_i);
    unique case (mode_q)
      MODE_IDLE: dec = take_idle(dec, in_byte_i);
      MODE_BSLASH: begin
        if (smap != 8'd0) begin
          dec = clear_esc(emit_b(dec, smap));
        end else if (is_oct(in_byte_i)) begin
          dec.mode = MODE_OCTAL;
          dec.val  = {29'd0, in_byte_i[2:0]};
          dec      = push_c(dec);
        end else if (in_byte_i == CH_X) begin
          dec.mode = MODE_HEX;
          dec.val  = '0;
          dec      = push_c(dec);
        end else begin
          dec = emit_b(dec, CH_BSLASH);
          dec = clear_esc(emit_b(dec, in_byte_i));
        end
      end
      MODE_OCTAL: begin
        if (is_oct(in_byte_i)) begin
          dec.val = {val_q[28:0], in_byte_i[2:0]};
          dec     = push_c(dec);
          if (dec.cnt >= CNT_W'(OCT_DIGITS)) dec = finish_esc(dec);
        end else begin
          dec = take_idle(finish_esc(dec), in_byte_i);
        end
      end
      MODE_HEX: begin
        if (hv[4]) begin
          dec.val = {val_q[27:0], hv[3:0]};
          dec     = push_c(dec);
        end else begin
          dec = take_idle(finish_esc(dec), in_byte_i);
        end
      end
    endcase
    if (in_last_i) dec = finish_esc(dec);
  end

  // escape state and sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      val_q   <= '0;
      cnt_q   <= '0;
      lost_q  <= 1'b0;
      idx_q   <= '0;
      s_cnt_q <= '0;
    end else if (cmd_i.take) begin
      mode_q  <= dec.mode;
      val_q   <= dec.val;
      cnt_q   <= dec.cnt;
      lost_q  <= dec.lost;
      idx_q   <= '0;
      s_cnt_q <= dec.s_cnt;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // only the written slot changes; the rest need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && dec.push) pend_q[cnt_q[IDX_W-1:0]] <= in_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rp_len_q <= dec.rp_len;
      rp_ovf_q <= dec.rp_ovf;
      s0_q     <= dec.s0;
      s1_q     <= dec.s1;
      last_q   <= in_last_i;
    end
  end

  logic [7:0] nxt_byte;
  logic       nxt_done, nxt_ovf;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_FIRST: begin
        nxt_byte = dec.rp_en ? CH_BSLASH : dec.s0;
        nxt_ovf  = dec.rp_en & dec.rp_ovf;
        nxt_done = cmd_i.last_run & in_last_i;
      end
      SEL_PEND: begin
        nxt_byte = pend_q[idx_q];
        nxt_ovf  = rp_ovf_q;
        nxt_done = cmd_i.last_run & last_q;
      end
      SEL_S0: begin
        nxt_byte = s0_q;
        nxt_ovf  = 1'b0;
        nxt_done = cmd_i.last_run & last_q;
      end
      SEL_S1: begin
        nxt_byte = s1_q;
        nxt_ovf  = 1'b0;
        nxt_done = cmd_i.last_run & last_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= nxt_byte;
      out_last_q <= cmd_i.last_run;
      out_done_q <= nxt_done;
      out_ovf_q  <= nxt_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;
  assign out_ovf_o   = out_ovf_q;

  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.dec_replay = dec.rp_en;
  assign status_o.dec_simple = dec.s_cnt;
  assign status_o.lat_simple = s_cnt_q;
  assign status_o.replay_end = ((CNT_W'(idx_q) + CNT_W'(1)) == rp_len_q);

  `CEU_ASSERT(a_no_overwrite, cmd_i.emit |-> (!out_valid_q || out_ready_i), "result overwritten")
  `CEU_ASSERT(a_replay_in_range,
    cmd_i.emit && (cmd_i.sel == SEL_PEND) |-> CNT_W'(idx_q) < rp_len_q, "replay index past end")
  `CEU_ASSERT_ALWAYS(a_idle_clean,
    mode_q == MODE_IDLE |-> (cnt_q == '0) && !lost_q && (val_q == '0), "idle with held chars")
  `CEU_ASSERT(a_octal_bound, mode_q == MODE_OCTAL |-> cnt_q < CNT_W'(OCT_DIGITS), "octal too long")

endmodule

`default_nettype wire
